### sv/scrm_pkg.sv
// Shared types and constants for the same-color rectangle merge block.
// Used by the controller, datapath, top level and testbench; no dependencies.

package scrm_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int PIXEL_WIDTH = 24;
   localparam int ENTRY_WIDTH = PIXEL_WIDTH + 1;   // covered flag on top of the pixel

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 9;
   localparam int SPAN_WIDTH      = 9;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPAN_ENABLE  = 2'd2;

   localparam logic [CSR_DATA_WIDTH-1:0] SIZE_RESET = 9'd256;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [1:0] CELL_COVERED = 2'd0;
   localparam logic [1:0] CELL_SINGLE  = 2'd1;
   localparam logic [1:0] CELL_SPAN    = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            cell_kind;
      logic [SPAN_WIDTH-1:0] row_span;
      logic [SPAN_WIDTH-1:0] col_span;
      logic [7:0]            red_out;
      logic [7:0]            green_out;
      logic [7:0]            blue_out;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_ORIGIN_RD,
      ST_ORIGIN_CHK,
      ST_ROW_RD,
      ST_ROW_CHK,
      ST_COL_RD,
      ST_COL_CHK,
      ST_DECIDE,
      ST_MARK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_ORIGIN,
      RD_ROW,
      RD_COL
   } rd_sel_type;

   typedef struct packed {
      logic       clear_write;
      logic       capture;
      logic       load_write;
      rd_sel_type rd_sel;
      logic       take_origin;
      logic       kind_en;
      logic [1:0] kind_val;
      logic       row_start;
      logic       col_step;
      logic       row_close;
      logic       mark_init;
      logic       mark_write;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_is_query;
      logic origin_outside;
      logic rd_free;
      logic rd_match;
      logic span_on;
      logic row_in;
      logic col_go;
      logic need_mark;
      logic mark_last;
      logic rsp_free;
   } status_type;

endpackage

### sv/scrm_stream_if.sv
// Valid/ready channel interface with a typed payload.
// Payload types come from scrm_pkg at the point of instantiation.

interface scrm_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/scrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module scrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/scrm_ctrl.sv
// Sequencer for store clearing, load, origin check, rectangle scan, cover marking and result.
// Depends on scrm_pkg for the state, command and status types.

module scrm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scrm_pkg::status_type status,
   output scrm_pkg::cmd_type    cmd
);

   scrm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scrm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scrm_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = scrm_pkg::ST_IDLE;
         end
         scrm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_is_query ? scrm_pkg::ST_ORIGIN_RD : scrm_pkg::ST_LOAD;
            end
         end
         scrm_pkg::ST_LOAD: state_in = scrm_pkg::ST_IDLE;
         scrm_pkg::ST_ORIGIN_RD: begin
            state_in = status.origin_outside ? scrm_pkg::ST_DONE : scrm_pkg::ST_ORIGIN_CHK;
         end
         scrm_pkg::ST_ORIGIN_CHK: begin
            if (!status.rd_free || !status.span_on) state_in = scrm_pkg::ST_DONE;
            else state_in = scrm_pkg::ST_ROW_RD;
         end
         scrm_pkg::ST_ROW_RD: begin
            state_in = status.row_in ? scrm_pkg::ST_ROW_CHK : scrm_pkg::ST_DECIDE;
         end
         scrm_pkg::ST_ROW_CHK: begin
            state_in = status.rd_match ? scrm_pkg::ST_COL_RD : scrm_pkg::ST_DECIDE;
         end
         scrm_pkg::ST_COL_RD: begin
            state_in = status.col_go ? scrm_pkg::ST_COL_CHK : scrm_pkg::ST_ROW_RD;
         end
         scrm_pkg::ST_COL_CHK: begin
            state_in = status.rd_match ? scrm_pkg::ST_COL_RD : scrm_pkg::ST_ROW_RD;
         end
         scrm_pkg::ST_DECIDE: begin
            state_in = status.need_mark ? scrm_pkg::ST_MARK : scrm_pkg::ST_DONE;
         end
         scrm_pkg::ST_MARK: begin
            if (status.mark_last) state_in = scrm_pkg::ST_DONE;
         end
         scrm_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = scrm_pkg::ST_IDLE;
         end
         default: state_in = scrm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = scrm_pkg::RD_ORIGIN;
      req_ready  = 1'b0;
      case (state_ff)
         scrm_pkg::ST_CLEAR: cmd.clear_write = 1'b1;
         scrm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         scrm_pkg::ST_LOAD: cmd.load_write = 1'b1;
         scrm_pkg::ST_ORIGIN_RD: begin
            if (status.origin_outside) begin
               cmd.kind_en  = 1'b1;
               cmd.kind_val = scrm_pkg::CELL_COVERED;
            end
         end
         scrm_pkg::ST_ORIGIN_CHK: begin
            cmd.kind_en = 1'b1;
            if (!status.rd_free) begin
               cmd.kind_val = scrm_pkg::CELL_COVERED;
            end else begin
               cmd.kind_val    = scrm_pkg::CELL_SINGLE;
               cmd.take_origin = 1'b1;
            end
         end
         scrm_pkg::ST_ROW_RD: cmd.rd_sel = scrm_pkg::RD_ROW;
         scrm_pkg::ST_ROW_CHK: cmd.row_start = status.rd_match;
         scrm_pkg::ST_COL_RD: begin
            cmd.rd_sel    = scrm_pkg::RD_COL;
            cmd.row_close = !status.col_go;
         end
         scrm_pkg::ST_COL_CHK: begin
            cmd.col_step  = status.rd_match;
            cmd.row_close = !status.rd_match;
         end
         scrm_pkg::ST_DECIDE: begin
            if (status.need_mark) begin
               cmd.mark_init = 1'b1;
               cmd.kind_en   = 1'b1;
               cmd.kind_val  = scrm_pkg::CELL_SPAN;
            end
         end
         scrm_pkg::ST_MARK: cmd.mark_write = 1'b1;
         scrm_pkg::ST_DONE: cmd.emit = status.rsp_free;
         default: ;
      endcase
   end

endmodule

### sv/scrm_datapath.sv
// Datapath: size/span registers, image store, scan counters and result register.
// Depends on scrm_pkg and instantiates scrm_ram for the pixel-and-covered store.

module scrm_datapath #(
   parameter int MAX_WIDTH  = scrm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = scrm_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [scrm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [scrm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  scrm_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output scrm_pkg::rsp_payload_type              rsp_payload,
   input  scrm_pkg::cmd_type                      cmd,
   output scrm_pkg::status_type                   status
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int FW    = CW + RW;
   localparam int EW    = scrm_pkg::ENTRY_WIDTH;
   localparam int PW    = scrm_pkg::PIXEL_WIDTH;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] col,
                                              input logic [RW-1:0] row);
      logic [FW-1:0] full;
      full = FW'(row) * FW'(MAX_WIDTH) + FW'(col);
      return full[AW-1:0];
   endfunction

   function automatic logic [CW-1:0] clamp_w(input logic [scrm_pkg::CSR_DATA_WIDTH-1:0] v);
      logic [CW-1:0] res;
      if (v == '0) res = CW'(1);
      else if (32'(v) > MAX_WIDTH) res = CW'(MAX_WIDTH);
      else res = CW'(v);
      return res;
   endfunction

   function automatic logic [RW-1:0] clamp_h(input logic [scrm_pkg::CSR_DATA_WIDTH-1:0] v);
      logic [RW-1:0] res;
      if (v == '0) res = RW'(1);
      else if (32'(v) > MAX_HEIGHT) res = RW'(MAX_HEIGHT);
      else res = RW'(v);
      return res;
   endfunction

   // configuration
   logic [CW-1:0] w_ff;
   logic [RW-1:0] h_ff;
   logic          span_ff;

   // current item
   logic          kind_ff;
   logic [7:0]    x_ff, y_ff;
   logic [PW-1:0] rgb_ff;
   logic [1:0]    res_kind_ff;

   // scan and mark counters
   logic [RW-1:0] r_ff, rows_ff, mr_ff;
   logic [CW-1:0] c_ff, cols_ff, mc_ff;
   logic [AW-1:0] clr_addr_ff;

   logic                      rsp_valid_ff;
   scrm_pkg::rsp_payload_type rsp_payload_ff;
   scrm_pkg::rsp_payload_type rsp_payload_in;

   logic [CW-1:0] x_col;
   logic [RW-1:0] y_row;
   logic [CW-1:0] run;
   logic          load_in_store;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;

   assign x_col         = CW'(x_ff);
   assign y_row         = RW'(y_ff);
   assign run           = c_ff - x_col;
   assign load_in_store = (32'(x_ff) < MAX_WIDTH) && (32'(y_ff) < MAX_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= clamp_w(scrm_pkg::SIZE_RESET);
         h_ff    <= clamp_h(scrm_pkg::SIZE_RESET);
         span_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            scrm_pkg::CSR_IMAGE_WIDTH:  w_ff    <= clamp_w(csr_wdata);
            scrm_pkg::CSR_IMAGE_HEIGHT: h_ff    <= clamp_h(csr_wdata);
            scrm_pkg::CSR_SPAN_ENABLE:  span_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_payload.kind;
         x_ff    <= req_payload.pos_x;
         y_ff    <= req_payload.pos_y;
         rgb_ff  <= {req_payload.red_in, req_payload.green_in, req_payload.blue_in};
      end else if (cmd.take_origin) begin
         rgb_ff  <= ram_rdata[PW-1:0];
      end
      if (cmd.kind_en) res_kind_ff <= cmd.kind_val;

      if (cmd.take_origin) begin
         r_ff    <= y_row;
         rows_ff <= '0;
         cols_ff <= '0;
      end else if (cmd.row_close) begin
         if (cols_ff == '0 || run < cols_ff) cols_ff <= run;
         rows_ff <= rows_ff + RW'(1);
         r_ff    <= r_ff + RW'(1);
      end

      if (cmd.row_start) c_ff <= x_col + CW'(1);
      else if (cmd.col_step) c_ff <= c_ff + CW'(1);

      if (cmd.mark_init) begin
         mr_ff <= '0;
         mc_ff <= '0;
      end else if (cmd.mark_write) begin
         if (mc_ff == cols_ff - CW'(1)) begin
            mc_ff <= '0;
            mr_ff <= mr_ff + RW'(1);
         end else begin
            mc_ff <= mc_ff + CW'(1);
         end
      end
   end

   // store port selection
   always_comb begin
      case (cmd.rd_sel)
         scrm_pkg::RD_ROW: ram_raddr = addr_of(x_col, r_ff);
         scrm_pkg::RD_COL: ram_raddr = addr_of(c_ff, r_ff);
         default:          ram_raddr = addr_of(x_col, y_row);
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_of(x_col, y_row);
      ram_wdata = {1'b0, rgb_ff};
      if (cmd.clear_write) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else if (cmd.mark_write) begin
         ram_we    = 1'b1;
         ram_waddr = addr_of(x_col + mc_ff, y_row + mr_ff);
         ram_wdata = {1'b1, rgb_ff};
      end else if (cmd.load_write) begin
         ram_we    = load_in_store;
      end
   end

   scrm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_payload_in = '0;
      case (res_kind_ff)
         scrm_pkg::CELL_SINGLE: begin
            rsp_payload_in.cell_kind = scrm_pkg::CELL_SINGLE;
            rsp_payload_in.row_span  = scrm_pkg::SPAN_WIDTH'(1);
            rsp_payload_in.col_span  = scrm_pkg::SPAN_WIDTH'(1);
            rsp_payload_in.red_out   = rgb_ff[23:16];
            rsp_payload_in.green_out = rgb_ff[15:8];
            rsp_payload_in.blue_out  = rgb_ff[7:0];
         end
         scrm_pkg::CELL_SPAN: begin
            rsp_payload_in.cell_kind = scrm_pkg::CELL_SPAN;
            rsp_payload_in.row_span  = scrm_pkg::SPAN_WIDTH'(rows_ff);
            rsp_payload_in.col_span  = scrm_pkg::SPAN_WIDTH'(cols_ff);
            rsp_payload_in.red_out   = rgb_ff[23:16];
            rsp_payload_in.green_out = rgb_ff[15:8];
            rsp_payload_in.blue_out  = rgb_ff[7:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      status                = '0;
      status.clear_last     = (clr_addr_ff == AW'(DEPTH - 1));
      status.req_is_query   = (req_payload.kind == scrm_pkg::KIND_QUERY);
      status.origin_outside = (kind_ff == scrm_pkg::KIND_QUERY)
                              && ((32'(x_ff) >= 32'(w_ff)) || (32'(y_ff) >= 32'(h_ff)));
      status.rd_free        = !ram_rdata[EW-1];
      status.rd_match       = (ram_rdata == {1'b0, rgb_ff});
      status.span_on        = span_ff;
      status.row_in         = (r_ff < h_ff);
      status.col_go         = (c_ff < w_ff) && ((cols_ff == '0) || (run < cols_ff));
      status.need_mark      = (rows_ff > RW'(1)) || (cols_ff > CW'(1));
      status.mark_last      = (mc_ff == cols_ff - CW'(1)) && (mr_ff == rows_ff - RW'(1));
      status.rsp_free       = !rsp_valid_ff || rsp_ready;
   end

endmodule

### sv/same_color_rectangle_merge.sv
// Top level of the same-color rectangle merge block.
// Depends on scrm_pkg and scrm_stream_if; instantiates scrm_ctrl and scrm_datapath.
//
// After reset the block runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT store
// entries (65536 at the defaults), holding req ready low; configuration writes
// are taken throughout. Items are handled one at a time. A load is captured and
// then written. A query outside the image goes straight to its result; a query on
// a covered cell or with spanning off ends after its origin read and check. With
// spanning on, a query on an uncovered cell scans the rectangle row by row (the
// store has one read port with registered read data, so each probe is an address
// state and a compare state); a row closes when it stops at the right edge or at
// the narrowest run so far, the scan ends when it runs off the bottom edge, and a
// marked rectangle larger than 1x1 is then covered pixel by pixel. The result sits
// in an output register, so the next item is accepted while it waits to be taken;
// a later query holds its result until the waiting one is taken.

module same_color_rectangle_merge #(
   parameter int MAX_WIDTH  = scrm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = scrm_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   scrm_stream_if.sink                          req_ch,
   scrm_stream_if.source                        rsp_ch,
   input  logic                                 csr_we,
   input  logic [scrm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [scrm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   scrm_pkg::cmd_type         cmd;
   scrm_pkg::status_type      status;
   scrm_pkg::req_payload_type req_payload;
   scrm_pkg::rsp_payload_type rsp_payload;
   logic                      req_ready;
   logic                      rsp_valid;

   assign req_payload    = req_ch.payload;
   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_payload;

   scrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scrm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### tb/same_color_rectangle_merge_test.sv
// Self-checking testbench for same_color_rectangle_merge: loads images, queries cells
// and compares each result beat against a local prediction of the rectangle merge.
// Depends on scrm_pkg, scrm_stream_if and the same_color_rectangle_merge top level.

module same_color_rectangle_merge_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_W     = scrm_pkg::DEF_MAX_WIDTH;
   localparam int STORE_H     = scrm_pkg::DEF_MAX_HEIGHT;
   localparam int SETTLE      = 32;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int ITEM_TARGET = 1500;
   localparam logic [scrm_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   // Tracks the image, the covered map and the size registers; predicts each query.
   class merge_scoreboard;
      bit [23:0] pixels [STORE_W*STORE_H];
      bit        covered [STORE_W*STORE_H];
      bit        written [STORE_W*STORE_H];
      logic [scrm_pkg::CSR_DATA_WIDTH-1:0] width_reg  = scrm_pkg::SIZE_RESET;
      logic [scrm_pkg::CSR_DATA_WIDTH-1:0] height_reg = scrm_pkg::SIZE_RESET;
      logic                                span_on    = 1'b0;
      scrm_pkg::rsp_payload_type           expected_cells [$];
      int                                  failures   = 0;

      function int unsigned eff_size(logic [scrm_pkg::CSR_DATA_WIDTH-1:0] v,
                                     int unsigned limit);
         if (v == 0) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      function int unsigned slot(int unsigned x, int unsigned y);
         return y * STORE_W + x;
      endfunction

      function bit open_match(int unsigned x, int unsigned y, logic [23:0] colour);
         return pixels[slot(x, y)] == colour && !covered[slot(x, y)];
      endfunction

      function void write_csr(logic [scrm_pkg::CSR_INDEX_WIDTH-1:0] index,
                              logic [scrm_pkg::CSR_DATA_WIDTH-1:0] data);
         case (index)
            scrm_pkg::CSR_IMAGE_WIDTH:  width_reg = data;
            scrm_pkg::CSR_IMAGE_HEIGHT: height_reg = data;
            scrm_pkg::CSR_SPAN_ENABLE:  span_on = data[0];
            default: ;
         endcase
      endfunction

      // True when a query here reads only pixels that were loaded at some point.
      function bit scan_safe(int unsigned x, int unsigned y);
         int unsigned w, h;
         w = eff_size(width_reg, STORE_W);
         h = eff_size(height_reg, STORE_H);
         if (x >= w || y >= h || covered[slot(x, y)]) return 1;
         if (!span_on) return written[slot(x, y)];
         for (int unsigned r = y; r < h; r++)
            for (int unsigned c = x; c < w; c++)
               if (!written[slot(c, r)]) return 0;
         return 1;
      endfunction

      function void accept_item(scrm_pkg::req_payload_type item);
         int unsigned w, h, x, y, rows, cols, run, r, c;
         logic [23:0] colour;
         scrm_pkg::rsp_payload_type outcome;
         w = eff_size(width_reg, STORE_W);
         h = eff_size(height_reg, STORE_H);
         x = item.pos_x;
         y = item.pos_y;
         if (item.kind == scrm_pkg::KIND_LOAD) begin
            pixels[slot(x, y)]  = {item.red_in, item.green_in, item.blue_in};
            covered[slot(x, y)] = 1'b0;
            written[slot(x, y)] = 1'b1;
            return;
         end
         outcome = '0;
         if (x < w && y < h && !covered[slot(x, y)]) begin
            colour = pixels[slot(x, y)];
            outcome.cell_kind = scrm_pkg::CELL_SINGLE;
            outcome.row_span  = scrm_pkg::SPAN_WIDTH'(1);
            outcome.col_span  = scrm_pkg::SPAN_WIDTH'(1);
            {outcome.red_out, outcome.green_out, outcome.blue_out} = colour;
            if (span_on) begin
               rows = 0;
               cols = 0;
               r = y;
               // grow downward; the column span is the narrowest run seen
               while (r < h && open_match(x, r, colour)) begin
                  run = 0;
                  c = x;
                  while (c < w && open_match(c, r, colour)) begin
                     run++;
                     c++;
                  end
                  if (cols == 0 || run < cols) cols = run;
                  rows++;
                  r++;
               end
               if (rows > 1 || cols > 1) begin
                  for (r = 0; r < rows; r++)
                     for (c = 0; c < cols; c++)
                        covered[slot(x + c, y + r)] = 1'b1;
                  outcome.cell_kind = scrm_pkg::CELL_SPAN;
                  outcome.row_span  = scrm_pkg::SPAN_WIDTH'(rows);
                  outcome.col_span  = scrm_pkg::SPAN_WIDTH'(cols);
               end
            end
         end
         expected_cells.push_back(outcome);
      endfunction

      function void log_failure(string text);
         failures++;
         if (failures <= 10) $display("%0t: %s", $realtime, text);
      endfunction

      function void check_cell(scrm_pkg::rsp_payload_type got);
         scrm_pkg::rsp_payload_type want;
         if (expected_cells.size() == 0) begin
            log_failure($sformatf("result with nothing expected: kind=%0d rows=%0d cols=%0d",
                                  got.cell_kind, got.row_span, got.col_span));
            return;
         end
         want = expected_cells.pop_front();
         if (got.cell_kind !== want.cell_kind || got.row_span !== want.row_span ||
             got.col_span !== want.col_span || got.red_out !== want.red_out ||
             got.green_out !== want.green_out || got.blue_out !== want.blue_out)
            log_failure({
               $sformatf("mismatch: expected kind=%0d rows=%0d cols=%0d rgb=%02h%02h%02h",
                         want.cell_kind, want.row_span, want.col_span,
                         want.red_out, want.green_out, want.blue_out),
               $sformatf(", got kind=%0d rows=%0d cols=%0d rgb=%02h%02h%02h",
                         got.cell_kind, got.row_span, got.col_span,
                         got.red_out, got.green_out, got.blue_out)});
      endfunction

      function int pending();
         return expected_cells.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                                 csr_we;
   logic [scrm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [scrm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   scrm_stream_if #(.payload_type(scrm_pkg::req_payload_type)) req_if ();
   scrm_stream_if #(.payload_type(scrm_pkg::rsp_payload_type)) rsp_if ();

   same_color_rectangle_merge u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   merge_scoreboard tracker = new();
   int          items_sent = 0;
   int          burst_left = 0;
   int          cycle_count;
   logic [23:0] palette [3];
   int unsigned block_w = 1;
   int unsigned block_h = 1;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: switch between always-ready, random stall masks and a mostly-stalled mask.
   initial begin
      logic [15:0] mask;
      int          mode;
      int          stretch;
      rsp_if.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         case (mode)
            0:       mask = '1;
            3:       mask = 16'h0001;
            default: mask = 16'($urandom) | 16'h8000;
         endcase
         stretch = $urandom_range(40, 300);
         for (int k = 0; k < stretch; k++) begin
            @(negedge clock);
            rsp_if.ready = mask[k % 16];
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready)
         tracker.check_cell(rsp_if.payload);

   task automatic send_item(input logic kind, input int unsigned x, input int unsigned y,
                            input logic [23:0] rgb);
      scrm_pkg::req_payload_type beat;
      int unsigned               gap;
      beat.kind     = kind;
      beat.pos_x    = x[7:0];
      beat.pos_y    = y[7:0];
      beat.red_in   = rgb[23:16];
      beat.green_in = rgb[15:8];
      beat.blue_in  = rgb[7:0];
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_if.valid   = 1'b1;
      req_if.payload = beat;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.accept_item(beat);
      burst_left--;
      items_sent++;
   endtask

   task automatic write_csr(input logic [scrm_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [scrm_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      tracker.write_csr(index, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Hold valid low until every result is back, then let trailing loads finish.
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [23:0] paint(int unsigned x, int unsigned y);
      if ($urandom_range(0, 9) == 0) return palette[2];
      return palette[((x / block_w) + (y / block_h)) % 2];
   endfunction

   task automatic run_phase(input logic [scrm_pkg::CSR_DATA_WIDTH-1:0] w_reg,
                            input logic [scrm_pkg::CSR_DATA_WIDTH-1:0] h_reg,
                            input logic span_bit, input int mixed);
      int unsigned w, h, x, y, roll;
      drain();
      write_csr(scrm_pkg::CSR_IMAGE_WIDTH, w_reg);
      write_csr(scrm_pkg::CSR_IMAGE_HEIGHT, h_reg);
      write_csr(scrm_pkg::CSR_SPAN_ENABLE, {8'($urandom), span_bit});
      w = tracker.eff_size(w_reg, STORE_W);
      h = tracker.eff_size(h_reg, STORE_H);
      palette[0] = 24'($urandom);
      palette[1] = ($urandom_range(0, 3) == 0) ? palette[0] : 24'($urandom);
      palette[2] = 24'($urandom);
      block_w = $urandom_range(1, 4);
      block_h = $urandom_range(1, 4);
      for (y = 0; y < h; y++)
         for (x = 0; x < w; x++)
            send_item(scrm_pkg::KIND_LOAD, x, y, paint(x, y));
      for (int n = 0; n < mixed; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            if ($urandom_range(0, 6) == 0 && (w < STORE_W || h < STORE_H)) begin
               if (w < STORE_W && (h == STORE_H || $urandom_range(0, 1) == 0)) begin
                  x = $urandom_range(w, STORE_W - 1);
                  y = $urandom_range(0, STORE_H - 1);
               end else begin
                  x = $urandom_range(0, STORE_W - 1);
                  y = $urandom_range(h, STORE_H - 1);
               end
               send_item(scrm_pkg::KIND_QUERY, x, y, 24'($urandom));
            end else begin
               x = $urandom_range(0, w - 1);
               y = $urandom_range(0, h - 1);
               if (tracker.scan_safe(x, y))
                  send_item(scrm_pkg::KIND_QUERY, x, y, 24'($urandom));
               else
                  send_item(scrm_pkg::KIND_LOAD, x, y, paint(x, y));
            end
         end else if (roll < 85) begin
            // repaint inside the image; this uncovers the pixel
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
            send_item(scrm_pkg::KIND_LOAD, x, y,
                      ($urandom_range(0, 7) == 0) ? 24'($urandom) : paint(x, y));
         end else begin
            send_item(scrm_pkg::KIND_LOAD, $urandom_range(0, STORE_W - 1),
                      $urandom_range(0, STORE_H - 1), 24'($urandom));
         end
      end
   endtask

   initial begin
      logic [23:0] hue_a;
      logic [23:0] hue_b;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_we         = 1'b0;
      csr_index      = scrm_pkg::CSR_IMAGE_WIDTH;
      csr_wdata      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // 3x2 image: all black but one white pixel in the bottom right corner
      hue_a = 24'h000000;
      hue_b = 24'hffffff;
      write_csr(scrm_pkg::CSR_IMAGE_WIDTH, 9'd3);
      write_csr(scrm_pkg::CSR_IMAGE_HEIGHT, 9'd2);
      write_csr(scrm_pkg::CSR_SPAN_ENABLE, 9'd0);
      for (int y = 0; y < 2; y++)
         for (int x = 0; x < 3; x++)
            send_item(scrm_pkg::KIND_LOAD, x, y, (x == 2 && y == 1) ? hue_b : hue_a);
      send_item(scrm_pkg::KIND_QUERY, 0, 0, 24'h0);
      send_item(scrm_pkg::KIND_QUERY, 2, 1, 24'hffffff);
      send_item(scrm_pkg::KIND_QUERY, 3, 0, 24'h0);
      send_item(scrm_pkg::KIND_QUERY, 0, 2, 24'h0);
      drain();
      write_csr(scrm_pkg::CSR_SPAN_ENABLE, 9'd1);
      send_item(scrm_pkg::KIND_QUERY, 0, 0, 24'h0);   // 2x2 rectangle
      send_item(scrm_pkg::KIND_QUERY, 1, 1, 24'h0);   // covered by it
      send_item(scrm_pkg::KIND_QUERY, 2, 0, 24'h0);   // 1x1, stays single
      send_item(scrm_pkg::KIND_QUERY, 2, 1, 24'h0);
      send_item(scrm_pkg::KIND_LOAD, 1, 1, hue_a);    // repaint uncovers
      send_item(scrm_pkg::KIND_QUERY, 1, 1, 24'h0);
      send_item(scrm_pkg::KIND_QUERY, 1, 0, 24'h0);
      send_item(scrm_pkg::KIND_QUERY, 255, 255, 24'h0);
      drain();
      // full-size image, probe only the far corner
      write_csr(scrm_pkg::CSR_IMAGE_WIDTH, 9'd511);
      write_csr(scrm_pkg::CSR_IMAGE_HEIGHT, 9'd256);
      write_csr(CSR_UNUSED, 9'($urandom));
      send_item(scrm_pkg::KIND_LOAD, 255, 255, 24'hffffff);
      send_item(scrm_pkg::KIND_QUERY, 255, 255, 24'h0);
      send_item(scrm_pkg::KIND_LOAD, 255, 255, 24'h000000);
      send_item(scrm_pkg::KIND_QUERY, 255, 255, 24'hffffff);
      drain();
      write_csr(scrm_pkg::CSR_SPAN_ENABLE, 9'd0);
      send_item(scrm_pkg::KIND_QUERY, 255, 255, 24'h0);

      run_phase(9'd0, 9'd5, 1'b1, 30);
      run_phase(9'd256, 9'd1, 1'b1, 30);
      run_phase(9'd1, 9'd256, 1'b1, 30);
      run_phase(9'd511, 9'd2, 1'b1, 30);
      run_phase(9'd16, 9'd0, 1'b1, 30);
      while (items_sent < ITEM_TARGET)
         run_phase(($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 12)),
                   ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 12)),
                   ($urandom_range(0, 3) != 0), $urandom_range(40, 80));
      drain();

      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
